/* src/pid_variable_speed_integral_core_assert.svh */
// ----------------------------------------------------------------------------
// PID core assertion macros
// Shared forms for the concurrent checks of the PID core.
// ----------------------------------------------------------------------------
`ifndef PID_VARIABLE_SPEED_INTEGRAL_CORE_ASSERT_SVH
`define PID_VARIABLE_SPEED_INTEGRAL_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PVSI_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PVSI_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pvsi_pkg.sv */
// ----------------------------------------------------------------------------
// pvsi_pkg
// Widths, register indexes and shared types of the PID core.
// ----------------------------------------------------------------------------
package pvsi_pkg;

	// Serial multiplier operand widths
	localparam int MCAND_W   = 33;
	localparam int MPLIER_W  = 18;
	localparam int PROD_W    = MCAND_W + MPLIER_W;
	localparam int MUL_CNT_W = $clog2(MPLIER_W);

	// Serial divider width (quotient bits)
	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Register port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_PROP   = 3'd0;
	localparam logic [2:0] REG_INTEG  = 3'd1;
	localparam logic [2:0] REG_DERIV  = 3'd2;
	localparam logic [2:0] REG_THR_A  = 3'd3;
	localparam logic [2:0] REG_THR_B  = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;

	localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;

	// Status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* src/pvsi_mul.sv */
// ----------------------------------------------------------------------------
// pvsi_mul
// Signed shift-add multiplier, one multiplier bit per cycle, MSB weighted
// negative; product valid when done pulses.
// ----------------------------------------------------------------------------
module pvsi_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pvsi_pkg::MCAND_W-1:0]        mcand,
	input  logic [pvsi_pkg::MPLIER_W-1:0]       mplier,
	output pvsi_pkg::unit_stat_t                stat,
	output logic [pvsi_pkg::PROD_W-1:0]         product
);

	localparam int MW = pvsi_pkg::MCAND_W;
	localparam int YW = pvsi_pkg::MPLIER_W;
	localparam int CW = pvsi_pkg::MUL_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(YW - 1);

	logic [MW-1:0] mcand_q;
	logic [MW:0]   hi_q;
	logic [YW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          last_step;
	logic [MW:0]   mcand_ext;
	logic [MW:0]   addend;
	logic [MW:0]   hi_sum;

	// Add or, on the sign bit, subtract the multiplicand
	always_comb begin
		last_step = (cnt_q == LAST);
		mcand_ext = {mcand_q[MW-1], mcand_q};
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last_step) begin
			addend = (MW + 1)'(0) - mcand_ext;
		end else begin
			addend = mcand_ext;
		end
		hi_sum = hi_q + addend;
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift the partial product right one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (busy_q) begin
			hi_q <= {hi_sum[MW], hi_sum[MW:1]};
			lo_q <= {hi_sum[0], lo_q[YW-1:1]};
		end
	end

	assign product   = {hi_q[MW-1:0], lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* src/pvsi_div.sv */
// ----------------------------------------------------------------------------
// pvsi_div
// Restoring divider for (num << DIV_W) / den with num < den, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module pvsi_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pvsi_pkg::DIV_W-1:0]     num,
	input  logic [pvsi_pkg::DIV_W-1:0]     den,
	output pvsi_pkg::unit_stat_t           stat,
	output logic [pvsi_pkg::DIV_W-1:0]     quot
);

	localparam int DW = pvsi_pkg::DIV_W;
	localparam int CW = pvsi_pkg::DIV_CNT_W;
	localparam logic [CW-1:0] LAST = CW'(DW - 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_dbl;
	logic [DW:0]   rem_sub;
	logic          fits;

	// Trial subtract of the doubled remainder
	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_sub = rem_dbl - {1'b0, den_q};
		fits    = (rem_dbl >= {1'b0, den_q});
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sub[DW-1:0] : rem_dbl[DW-1:0];
			quot_q <= {quot_q[DW-2:0], fits};
		end
	end

	assign quot      = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* src/pid_variable_speed_integral_core.sv */
// ----------------------------------------------------------------------------
// pid_variable_speed_integral_core
// Positional PID with error-weighted trapezoidal integral, serial datapath.
// Tick channel (tick_valid/tick_ready, setpoint, measured) takes one control
// tick; result channel (result_valid/result_ready, drive, integ_clamped)
// returns one result per tick. Gains, thresholds and the integral limit must
// be written over the APB port only while no tick is in flight; the core does
// not enforce this. A tick runs the weight step, the divider if the error lies
// on the ramp of the integral weight, then four multiplies and rounding; a new
// tick is taken only once the last has left rounding. The products share one
// multiplier retiring a bit per cycle; the ramp weight uses a serial divider.
// A finished result waits in the output register; while the receiver stalls
// the next tick is still taken and computed, and the core holds it until the
// output register frees. Reset clears the integral, the previous error and
// measurement, and loads the register reset values.
// ----------------------------------------------------------------------------
`include "pid_variable_speed_integral_core_assert.svh"

module pid_variable_speed_integral_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pvsi_pkg::ADDR_W-1:0]       paddr,
	input  logic [pvsi_pkg::DATA_W-1:0]       pwdata,
	output logic [pvsi_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              tick_valid,
	output logic                              tick_ready,
	input  logic signed [15:0]                setpoint,
	input  logic signed [15:0]                measured,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic signed [31:0]                drive,
	output logic                              integ_clamped
);

	localparam int SUM_W = 49;
	localparam int INC_W = 27;
	localparam logic [16:0] W_ONE = 17'h10000;
	localparam logic [16:0] W_ZERO = 17'h00000;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WGT  = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_MW   = 4'd3;
	localparam logic [3:0] S_MW_W = 4'd4;
	localparam logic [3:0] S_ACC  = 4'd5;
	localparam logic [3:0] S_MP   = 4'd6;
	localparam logic [3:0] S_MP_W = 4'd7;
	localparam logic [3:0] S_MD   = 4'd8;
	localparam logic [3:0] S_MD_W = 4'd9;
	localparam logic [3:0] S_MI   = 4'd10;
	localparam logic [3:0] S_MI_W = 4'd11;
	localparam logic [3:0] S_RND  = 4'd12;

	// Configuration registers
	logic [15:0] prop_q;
	logic [15:0] integ_gain_q;
	logic [15:0] deriv_q;
	logic [15:0] thr_a_q;
	logic [15:0] thr_b_q;
	logic [30:0] limit_q;

	// Controller state
	logic [3:0]  state_q;
	logic [3:0]  state_d;
	logic [31:0] integ_q;
	logic [16:0] last_err_q;
	logic [15:0] last_meas_q;
	logic        result_valid_q;

	// Per-tick working registers
	logic [16:0]      e_q;
	logic [15:0]      mag_q;
	logic [17:0]      s_q;
	logic [16:0]      nd_q;
	logic [16:0]      w_q;
	logic [INC_W-1:0] inc_q;
	logic             clamp_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      drive_q;
	logic             result_clamped_q;

	logic        wr_en;
	logic        tick_xfer;
	logic [16:0] e_w;
	logic [16:0] mag_w;
	logic [17:0] s_w;
	logic [16:0] nd_w;
	logic [16:0] ab_w;
	logic [16:0] mag_ext;
	logic        wgt_use_div;
	logic [15:0] wgt_den;
	logic [16:0] wgt_fix;
	logic [16:0] div_num_w;

	logic                            mul_start;
	logic [pvsi_pkg::MCAND_W-1:0]    mul_mcand;
	logic [pvsi_pkg::MPLIER_W-1:0]   mul_mplier;
	pvsi_pkg::unit_stat_t            mul_stat;
	logic [pvsi_pkg::PROD_W-1:0]     mul_prod;
	logic                            div_start;
	pvsi_pkg::unit_stat_t            div_stat;
	logic [pvsi_pkg::DIV_W-1:0]      div_quot;

	logic [33:0]      acc_sum;
	logic [33:0]      lim_pos;
	logic [33:0]      lim_neg;
	logic             acc_over;
	logic             acc_under;
	logic [SUM_W-1:0] rnd_w;
	logic [32:0]      rnd_int;
	logic [31:0]      sat_w;
	logic             out_free;
	logic             rnd_load;

	// APB register access
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[4:2])
			pvsi_pkg::REG_PROP:  prdata = {16'd0, prop_q};
			pvsi_pkg::REG_INTEG: prdata = {16'd0, integ_gain_q};
			pvsi_pkg::REG_DERIV: prdata = {16'd0, deriv_q};
			pvsi_pkg::REG_THR_A: prdata = {16'd0, thr_a_q};
			pvsi_pkg::REG_THR_B: prdata = {16'd0, thr_b_q};
			pvsi_pkg::REG_LIMIT: prdata = {1'b0, limit_q};
			default:             prdata = '0;
		endcase
	end

	// Error, its magnitude, trapezoid sum and negated measurement change
	always_comb begin
		tick_xfer = tick_valid && tick_ready;
		e_w       = {setpoint[15], setpoint} - {measured[15], measured};
		mag_w     = e_w[16] ? (17'd0 - e_w) : e_w;
		s_w       = {e_w[16], e_w} + {last_err_q[16], last_err_q};
		nd_w      = {last_meas_q[15], last_meas_q} - {measured[15], measured};
	end

	// Pick the integral weight: fixed, or a ramp through the divider
	always_comb begin
		ab_w        = {1'b0, thr_a_q} + {1'b0, thr_b_q};
		mag_ext     = {1'b0, mag_q};
		div_num_w   = ab_w - mag_ext;
		wgt_use_div = 1'b0;
		wgt_den     = thr_a_q;
		wgt_fix     = W_ONE;
		if (thr_b_q < thr_a_q) begin
			if (mag_ext <= {1'b0, thr_b_q}) begin
				wgt_fix = W_ONE;
			end else if (mag_ext <= ab_w) begin
				wgt_use_div = 1'b1;
				wgt_den     = thr_a_q;
			end else begin
				wgt_fix = W_ZERO;
			end
		end else if (thr_b_q > thr_a_q) begin
			if (mag_ext <= {1'b0, thr_a_q}) begin
				wgt_fix = W_ZERO;
			end else if (mag_ext <= ab_w) begin
				wgt_use_div = 1'b1;
				wgt_den     = thr_b_q;
			end else begin
				wgt_fix = W_ONE;
			end
		end
	end

	assign div_start = (state_q == S_WGT) && wgt_use_div;

	// Steer the multiplier operands by step
	always_comb begin
		mul_start  = (state_q == S_MW) || (state_q == S_MP) || (state_q == S_MD) ||
			(state_q == S_MI);
		case (state_q)
			S_MW: begin
				mul_mcand  = {{15{s_q[17]}}, s_q};
				mul_mplier = {1'b0, w_q};
			end
			S_MP: begin
				mul_mcand  = {{16{e_q[16]}}, e_q};
				mul_mplier = {{2{prop_q[15]}}, prop_q};
			end
			S_MD: begin
				mul_mcand  = {{16{nd_q[16]}}, nd_q};
				mul_mplier = {{2{deriv_q[15]}}, deriv_q};
			end
			S_MI: begin
				mul_mcand  = {integ_q[31], integ_q};
				mul_mplier = {{2{integ_gain_q[15]}}, integ_gain_q};
			end
			default: begin
				mul_mcand  = '0;
				mul_mplier = '0;
			end
		endcase
	end

	// Add the increment and clamp to the limit
	always_comb begin
		acc_sum   = {{2{integ_q[31]}}, integ_q} + {{(34 - INC_W){inc_q[INC_W-1]}}, inc_q};
		lim_pos   = {3'd0, limit_q};
		lim_neg   = 34'd0 - lim_pos;
		acc_over  = $signed(acc_sum) > $signed(lim_pos);
		acc_under = $signed(acc_sum) < $signed(lim_neg);
	end

	// Round to integer units and saturate to 32 bits
	always_comb begin
		rnd_w   = sum_q + SUM_W'(32768);
		rnd_int = rnd_w[SUM_W-1:16];
		if (rnd_int[32] != rnd_int[31]) begin
			sat_w = rnd_int[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sat_w = rnd_int[31:0];
		end
		out_free = !result_valid_q || result_ready;
		rnd_load = (state_q == S_RND) && out_free;
	end

	// Sequence one tick through the shared units
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (tick_valid) state_d = S_WGT;
			S_WGT:  state_d = wgt_use_div ? S_DIV : S_MW;
			S_DIV:  if (div_stat.done) state_d = S_MW;
			S_MW:   state_d = S_MW_W;
			S_MW_W: if (mul_stat.done) state_d = S_ACC;
			S_ACC:  state_d = S_MP;
			S_MP:   state_d = S_MP_W;
			S_MP_W: if (mul_stat.done) state_d = S_MD;
			S_MD:   state_d = S_MD_W;
			S_MD_W: if (mul_stat.done) state_d = S_MI;
			S_MI:   state_d = S_MI_W;
			S_MI_W: if (mul_stat.done) state_d = S_RND;
			S_RND:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control state, configuration and controller memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prop_q         <= '0;
			integ_gain_q   <= '0;
			deriv_q        <= '0;
			thr_a_q        <= '0;
			thr_b_q        <= '0;
			limit_q        <= pvsi_pkg::LIMIT_RESET;
			integ_q        <= '0;
			last_err_q     <= '0;
			last_meas_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (paddr[4:2])
					pvsi_pkg::REG_PROP:  prop_q       <= pwdata[15:0];
					pvsi_pkg::REG_INTEG: integ_gain_q <= pwdata[15:0];
					pvsi_pkg::REG_DERIV: deriv_q      <= pwdata[15:0];
					pvsi_pkg::REG_THR_A: thr_a_q      <= pwdata[15:0];
					pvsi_pkg::REG_THR_B: thr_b_q      <= pwdata[15:0];
					pvsi_pkg::REG_LIMIT: limit_q      <= pwdata[30:0];
					default: ;
				endcase
			end
			if (tick_xfer) begin
				last_err_q  <= e_w;
				last_meas_q <= measured;
			end
			if (state_q == S_ACC) begin
				if (acc_over) begin
					integ_q <= lim_pos[31:0];
				end else if (acc_under) begin
					integ_q <= lim_neg[31:0];
				end else begin
					integ_q <= acc_sum[31:0];
				end
			end
			if (rnd_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the tick in flight
	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			e_q   <= e_w;
			mag_q <= mag_w[15:0];
			s_q   <= s_w;
			nd_q  <= nd_w;
		end
		if ((state_q == S_WGT) && !wgt_use_div) begin
			w_q <= wgt_fix;
		end
		if ((state_q == S_DIV) && div_stat.done) begin
			w_q <= {1'b0, div_quot};
		end
		if ((state_q == S_MW_W) && mul_stat.done) begin
			inc_q <= INC_W'(mul_prod[35:0] + 36'd256 >> 9);
		end
		if (state_q == S_ACC) begin
			clamp_q <= acc_over || acc_under;
		end
		if ((state_q == S_MP_W) && mul_stat.done) begin
			sum_q <= {mul_prod[40:0], 8'd0};
		end
		if ((state_q == S_MD_W) && mul_stat.done) begin
			sum_q <= sum_q + {mul_prod[40:0], 8'd0};
		end
		if ((state_q == S_MI_W) && mul_stat.done) begin
			sum_q <= sum_q + mul_prod[SUM_W-1:0];
		end
		if (rnd_load) begin
			drive_q          <= sat_w;
			result_clamped_q <= clamp_q;
		end
	end

	pvsi_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	pvsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_w[15:0]),
		.den    (wgt_den),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign tick_ready    = (state_q == S_IDLE);
	assign result_valid  = result_valid_q;
	assign drive         = drive_q;
	assign integ_clamped = result_clamped_q;

	// Checks
	`PVSI_ASSERT_IMPL(a_load_free, clk, arst_n, rnd_load, !result_valid_q || result_ready, "output register overwritten while a result waits")
	`PVSI_ASSERT_NEXT(a_tick_starts, clk, arst_n, tick_xfer, state_q == S_WGT, "accepted tick did not start the weight step")
	`PVSI_ASSERT_IMPL(a_mul_free, clk, arst_n, mul_start, !mul_stat.busy, "multiplier restarted while busy")
	`PVSI_ASSERT_IMPL(a_div_free, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`PVSI_ASSERT_IMPL(a_mul_done_wait, clk, arst_n, mul_stat.done, (state_q == S_MW_W) || (state_q == S_MP_W) || (state_q == S_MD_W) || (state_q == S_MI_W), "product finished outside a wait step")

endmodule

/* verif/pid_variable_speed_integral_core_tb.sv */
// ----------------------------------------------------------------------------
// pid_variable_speed_integral_core_tb
// Drives control ticks into the PID core and compares every drive and
// integ_clamped value with a cycle-free software copy of the controller.
// Gains, thresholds and the integral limit are rewritten over APB between
// phases. The phases cover no idling, a sender idle in most cycles, a
// receiver stalling in most cycles, and both sides idling now and then.
// ----------------------------------------------------------------------------
typedef struct {
	logic signed [31:0] drive;
	logic               clamped;
} drive_result_t;

// Software copy of the controller plus the queue of drive values it predicts
class drive_tracker;
	logic signed [15:0] kp, ki, kd;
	logic [15:0]        thr_a, thr_b;
	logic [30:0]        lim;
	longint             integ, prev_err, prev_meas;
	drive_result_t      drive_q[$];
	int                 errors;

	function void clear();
		kp = '0;
		ki = '0;
		kd = '0;
		thr_a = '0;
		thr_b = '0;
		lim = pvsi_pkg::LIMIT_RESET;
		integ = 0;
		prev_err = 0;
		prev_meas = 0;
		drive_q.delete();
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			pvsi_pkg::REG_PROP:  kp = val[15:0];
			pvsi_pkg::REG_INTEG: ki = val[15:0];
			pvsi_pkg::REG_DERIV: kd = val[15:0];
			pvsi_pkg::REG_THR_A: thr_a = val[15:0];
			pvsi_pkg::REG_THR_B: thr_b = val[15:0];
			pvsi_pkg::REG_LIMIT: lim = val[30:0];
			default: ;
		endcase
	endfunction

	// Integral weight in Q1.16 from the error magnitude
	function longint weight(longint mag);
		longint a, b, ab;
		a = longint'(thr_a);
		b = longint'(thr_b);
		ab = a + b;
		if (b < a) begin
			if (mag <= b) return 65536;
			if (mag <= ab) return ((ab - mag) << 16) / a;
			return 0;
		end
		if (b > a) begin
			if (mag <= a) return 0;
			if (mag <= ab) return ((ab - mag) << 16) / b;
			return 65536;
		end
		return 65536;
	endfunction

	// Advance the controller by one tick and queue the drive it yields
	function void take_tick(logic signed [15:0] sp, logic signed [15:0] ms);
		longint        e, mag, inc, bound, sum, d;
		drive_result_t r;
		e = longint'(sp) - longint'(ms);
		mag = (e < 0) ? -e : e;
		inc = ((e + prev_err) * weight(mag) + 256) >>> 9;
		bound = longint'(lim);
		integ = integ + inc;
		r.clamped = 1'b0;
		if (integ > bound) begin
			integ = bound;
			r.clamped = 1'b1;
		end
		if (integ < -bound) begin
			integ = -bound;
			r.clamped = 1'b1;
		end
		sum = longint'(kp) * e * 256 + longint'(ki) * integ
			- longint'(kd) * (longint'(ms) - prev_meas) * 256;
		d = (sum + 32768) >>> 16;
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		r.drive = d[31:0];
		prev_err = e;
		prev_meas = longint'(ms);
		drive_q.push_back(r);
	endfunction

	function void check_result(logic signed [31:0] drv, logic clmp);
		drive_result_t x;
		if (drive_q.size() == 0) begin
			$error("result transfer with no tick outstanding: drive %0d", drv);
			errors++;
			return;
		end
		x = drive_q.pop_front();
		if (drv !== x.drive) begin
			$error("drive: expected %0d, actual %0d", x.drive, drv);
			errors++;
		end
		if (clmp !== x.clamped) begin
			$error("integ_clamped: expected %0d, actual %0d", x.clamped, clmp);
			errors++;
		end
	endfunction

	function int pending();
		return drive_q.size();
	endfunction
endclass

module pid_variable_speed_integral_core_tb;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pvsi_pkg::ADDR_W-1:0]     paddr;
	logic [pvsi_pkg::DATA_W-1:0]     pwdata;
	logic [pvsi_pkg::DATA_W-1:0]     prdata;
	logic                            pready;
	logic                            tick_valid;
	logic                            tick_ready;
	logic signed [15:0]              setpoint;
	logic signed [15:0]              measured;
	logic                            result_valid;
	logic                            result_ready;
	logic signed [31:0]              drive;
	logic                            integ_clamped;

	drive_tracker tracker;
	int           send_idle_pct;
	int           recv_stall_pct;
	logic         holdoff_req;
	int           holdoff_left;

	pid_variable_speed_integral_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.tick_valid    (tick_valid),
		.tick_ready    (tick_ready),
		.setpoint      (setpoint),
		.measured      (measured),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.drive         (drive),
		.integ_clamped (integ_clamped)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Hard stop in case the core hangs
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (holdoff_req) begin
			holdoff_req <= 1'b0;
			holdoff_left = 400;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Observe transfers on both channels
	always @(posedge clk) begin
		if (arst_n && tracker != null) begin
			if (tick_valid && tick_ready)
				tracker.take_tick(setpoint, measured);
			if (result_valid && result_ready)
				tracker.check_result(drive, integ_clamped);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	// Write every register; junk in the unused upper bits must be ignored
	task automatic configure(input logic [15:0] p, input logic [15:0] i,
		input logic [15:0] d, input logic [15:0] a, input logic [15:0] b,
		input logic [30:0] lmt);
		apb_write(pvsi_pkg::REG_PROP, {16'($urandom), p});
		apb_write(pvsi_pkg::REG_INTEG, {16'($urandom), i});
		apb_write(pvsi_pkg::REG_DERIV, {16'($urandom), d});
		apb_write(pvsi_pkg::REG_THR_A, {16'($urandom), a});
		apb_write(pvsi_pkg::REG_THR_B, {16'($urandom), b});
		apb_write(pvsi_pkg::REG_LIMIT, {1'($urandom), lmt});
	endtask

	// Offer one tick; valid stays high after the transfer unless a gap follows
	task automatic send_tick(input logic signed [15:0] sp, input logic signed [15:0] ms);
		if ($urandom_range(99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		tick_valid <= 1'b1;
		setpoint <= sp;
		measured <= ms;
		do @(posedge clk); while (!tick_ready);
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic drain();
		tick_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Pick a setpoint/measured pair with the given error
	function automatic void place_error(input int e, output logic signed [15:0] sp,
		output logic signed [15:0] ms);
		int lo, hi, v;
		if (e > 65535) e = 65535;
		if (e < -65535) e = -65535;
		lo = (e > 0) ? -32768 + e : -32768;
		hi = (e > 0) ? 32767 : 32767 + e;
		v = lo + int'($urandom_range(hi - lo));
		sp = 16'(v);
		ms = 16'(v - e);
	endfunction

	// Errors around the thresholds or fully random pairs in equal share, the rest small
	function automatic void pick_tick(output logic signed [15:0] sp,
		output logic signed [15:0] ms);
		int mode, base, e;
		mode = $urandom_range(9);
		if (mode < 4) begin
			sp = 16'($urandom);
			ms = 16'($urandom);
		end else if (mode < 8) begin
			case ($urandom_range(2))
				0: base = int'(tracker.thr_a);
				1: base = int'(tracker.thr_b);
				default: base = int'(tracker.thr_a) + int'(tracker.thr_b);
			endcase
			e = base + int'($urandom_range(8)) - 4;
			if ($urandom_range(1)) e = -e;
			place_error(e, sp, ms);
		end else begin
			place_error(int'($urandom_range(64)) - 32, sp, ms);
		end
	endfunction

	task automatic run_phase(input int n, input int send_pct, input int recv_pct,
		input bit hold, input bit pause);
		logic signed [15:0] sp, ms;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold) holdoff_req <= 1'b1;
		for (int k = 0; k < n; k++) begin
			if (pause && k == n / 2) drain();
			pick_tick(sp, ms);
			send_tick(sp, ms);
		end
		drain();
	endtask

	int dir_sp [20] = '{0, 32767, -32768, 50, 0, 151, -249, 250, 0, 40,
		40, 40, 32767, -32768, -40, -40, -40, 1, -32768, 0};
	int dir_ms [20] = '{0, 32767, -32768, 0, 51, 1, 0, 0, 251, 0,
		0, 0, -32768, 32767, 0, 0, 0, -1, 0, -32768};

	initial begin
		logic [15:0] ta, tb;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_valid = 1'b0;
		setpoint = '0;
		measured = '0;
		result_ready = 1'b0;
		holdoff_req = 1'b0;
		holdoff_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		tracker = new();
		tracker.clear();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: weight edges at B and A+B, full-scale errors, negative clamp
		configure(16'h0100, 16'h0040, 16'h0080, 16'd200, 16'd50, 31'd20000);
		for (int k = 0; k < 20; k++)
			send_tick(16'(dir_sp[k]), 16'(dir_ms[k]));
		drain();

		// B below A, no idling
		ta = 16'($urandom_range(20000, 1000));
		tb = 16'($urandom_range(ta - 1));
		configure(16'($urandom), 16'($urandom), 16'($urandom), ta, tb,
			31'($urandom_range(1 << 24)));
		run_phase(85, 0, 0, 1'b0, 1'b0);

		// B above A, sender mostly idle
		tb = 16'($urandom_range(20000, 1000));
		ta = 16'($urandom_range(tb - 1));
		configure(16'($urandom), 16'($urandom), 16'($urandom), ta, tb,
			31'($urandom_range(1 << 20)));
		run_phase(85, 61, 0, 1'b0, 1'b0);

		// A equal to B, receiver mostly stalled, long hold-off and a full pause
		ta = 16'($urandom_range(30000, 1));
		configure(16'($urandom), 16'($urandom), 16'($urandom), ta, ta, 31'($urandom));
		run_phase(85, 0, 61, 1'b1, 1'b1);

		// Extremes: most negative P and D gains, most positive I gain, A zero, B full scale, zero limit
		configure(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF, 31'd0);
		run_phase(85, 10, 10, 1'b0, 1'b0);

		// Extremes: most positive P and D gains, most negative I gain, A full scale, B zero, full limit
		configure(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, pvsi_pkg::LIMIT_RESET);
		run_phase(85, 10, 10, 1'b0, 1'b0);

		// Both thresholds zero, random gains
		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0,
			31'($urandom_range(1 << 26)));
		run_phase(85, 0, 0, 1'b0, 1'b0);

		repeat (120) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/pvsi_pkg.sv
src/pvsi_mul.sv
src/pvsi_div.sv
src/pid_variable_speed_integral_core.sv
verif/pid_variable_speed_integral_core_tb.sv
